FILE: src/ars_pkg.sv
// Shared types, tags and codes for the AVI RIFF header scanner.
package ars_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  // Compare width: holds position plus size plus header length without wrap.
  localparam int CW = 35;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_AVI  = 32'h2049_5641;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_HDRL = 32'h6C72_6468;
  localparam logic [31:0] TAG_AVIH = 32'h6869_7661;
  localparam logic [31:0] TAG_MOVI = 32'h6976_6F6D;
  localparam logic [31:0] TAG_IDX1 = 32'h3178_6469;
  localparam logic [31:0] AVIH_GAP = 32'h0000_000C;
  localparam logic [31:0] AVIH_MIN = 32'd20;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF   = 3'd1;
  localparam logic [2:0] ST_NOT_AVI    = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_MISSING    = 3'd4;
  localparam logic [2:0] ST_SHORT_AVIH = 3'd5;

  typedef enum logic [3:0] {
    PH_RIFF_TAG, PH_RIFF_SIZE, PH_FORM, PH_HDR_TAG, PH_HDR_SIZE, PH_LIST_TYPE,
    PH_SKIP, PH_SUB_TAG, PH_SUB_SIZE, PH_USEC, PH_GAP, PH_FRAMES, PH_SUB_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } ars_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] movi_offset;
    logic [31:0] movi_size;
    logic [31:0] index_offset;
    logic [31:0] index_size;
    logic [31:0] usec_per_frame;
    logic [31:0] frame_count;
  } ars_out_t;

endpackage

FILE: src/avi_riff_header_scanner.sv
// Top level of the AVI RIFF header scanner: input register, parser, result register.
//
//   channel | signals                            | carries
//   input   | byte_valid, byte_stall, byte_data  | one file byte and end-of-file mark
//   output  | result_valid, result_stall, result | status and collected fields
//
// One byte per cycle while the result is not stalled: each byte passes the input
// register, one parse step and, on the end-of-file byte, the result register, which
// loads the result beat from the parse step on that byte.
// Reset (rst, synchronous) clears the parse state; no clearing pass is needed.
// A stalled result stops parsing; the input register then fills and
// byte_stall rises until the result beat is taken.
module avi_riff_header_scanner #(
  parameter int OFFSET_WIDTH = ars_pkg::OFFSET_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  ars_pkg::ars_in_t  byte_data,
  output logic              result_valid,
  input  logic              result_stall,
  output ars_pkg::ars_out_t result
);
  import ars_pkg::*;

  logic     in_full;
  ars_in_t  in_q;
  logic     step;
  ars_out_t res_c;

  assign step = in_full && (!result_valid || !result_stall);
  assign byte_stall = in_full && !step;

  // Hold the input beat until the parser takes it.
  always_ff @(posedge clk) begin
    if (rst) in_full <= 1'b0;
    else if (byte_valid && !byte_stall) in_full <= 1'b1;
    else if (step) in_full <= 1'b0;
    if (byte_valid && !byte_stall) in_q <= byte_data;
  end

  ars_parse #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_parse (
    .clk(clk), .rst(rst), .step(step), .beat(in_q), .result(res_c)
  );

  // Load the result beat on the last byte; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (step && in_q.end_of_file) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
    if (step && in_q.end_of_file) result <= res_c;
  end

endmodule

FILE: src/ars_parse.sv
// Parse state and one-byte step logic of the AVI RIFF header scanner.
module ars_parse #(
  parameter int OFFSET_WIDTH = ars_pkg::OFFSET_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ars_pkg::ars_in_t beat,
  output ars_pkg::ars_out_t result
);
  import ars_pkg::*;

  localparam int PW = OFFSET_WIDTH + 1;

  logic [PW-1:0] pos, pos_next;
  phase_t        phase, phase_next;
  logic [31:0]   shift, shift_next;
  logic [1:0]    cnt, cnt_next;
  logic [31:0]   tag, tag_next;
  logic [32:0]   limit, limit_next;
  logic [32:0]   skip, skip_next;
  logic [33:0]   hle, hle_next;
  logic [31:0]   osz, osz_next;
  logic [31:0]   isz, isz_next;
  logic [31:0]   movi_off, movi_off_next, movi_sz, movi_sz_next;
  logic [31:0]   idx_off, idx_off_next, idx_sz, idx_sz_next;
  logic [31:0]   usec, usec_next, frames, frames_next;
  logic [2:0]    err, err_next;

  logic [CW-1:0] pos_x, tgt, hrest;
  logic [31:0]   f, rest;
  logic          do_top, do_sub, top_f, sub_f;
  logic [32:0]   top_amt, sub_amt;
  logic [2:0]    fc, status;

  // Advance position with saturation, then consume the byte.
  always_comb begin
    pos_next = (pos == '1) ? pos : pos + PW'(1);
    pos_x = CW'(pos_next);
    phase_next = phase; shift_next = shift; cnt_next = cnt; tag_next = tag;
    limit_next = limit; skip_next = skip; hle_next = hle; osz_next = osz;
    isz_next = isz; movi_off_next = movi_off; movi_sz_next = movi_sz;
    idx_off_next = idx_off; idx_sz_next = idx_sz; usec_next = usec;
    frames_next = frames; err_next = err;
    do_top = 1'b0; do_sub = 1'b0; top_f = 1'b0; sub_f = 1'b0;
    top_amt = '0; sub_amt = '0; hrest = '0;
    f = {beat.data_byte, shift[31:8]};
    rest = (osz >= 32'd4) ? osz - 32'd4 : 32'd0;
    case (phase)
      PH_DONE: begin
      end
      PH_SKIP, PH_SUB_SKIP, PH_GAP: begin
        skip_next = skip - 33'd1;
        if (skip_next == '0) begin
          if (phase == PH_SKIP) top_f = 1'b1;
          else if (phase == PH_SUB_SKIP) sub_f = 1'b1;
          else phase_next = PH_FRAMES;
        end
      end
      default: begin
        shift_next = f;
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          case (phase)
            PH_RIFF_TAG: begin
              if (f != TAG_RIFF) begin
                err_next = ST_NOT_RIFF; phase_next = PH_DONE;
              end else phase_next = PH_RIFF_SIZE;
            end
            PH_RIFF_SIZE: begin
              limit_next = 33'(f) + 33'd8;
              phase_next = PH_FORM;
            end
            PH_FORM: begin
              if (f != TAG_AVI) begin
                err_next = ST_NOT_AVI; phase_next = PH_DONE;
              end else top_f = 1'b1;
            end
            PH_HDR_TAG: begin
              tag_next = f; phase_next = PH_HDR_SIZE;
            end
            PH_HDR_SIZE: begin
              osz_next = f;
              if (tag == TAG_LIST) phase_next = PH_LIST_TYPE;
              else begin
                if (tag == TAG_IDX1) begin
                  idx_off_next = 32'(pos_next[OFFSET_WIDTH-1:0]);
                  idx_sz_next = f;
                end
                do_top = 1'b1; top_amt = 33'(f) + 33'(f[0]);
              end
            end
            PH_LIST_TYPE: begin
              if (f == TAG_HDRL) begin
                hle_next = 34'(pos_next) + 34'(rest);
                sub_f = 1'b1;
              end else begin
                if (f == TAG_MOVI) begin
                  movi_off_next = 32'(pos_next[OFFSET_WIDTH-1:0]);
                  movi_sz_next = rest;
                end
                do_top = 1'b1; top_amt = 33'(rest) + 33'(osz[0]);
              end
            end
            PH_SUB_TAG: begin
              tag_next = f; phase_next = PH_SUB_SIZE;
            end
            PH_SUB_SIZE: begin
              isz_next = f;
              if (tag == TAG_AVIH) begin
                if (f < AVIH_MIN) begin
                  err_next = ST_SHORT_AVIH; phase_next = PH_DONE;
                end else phase_next = PH_USEC;
              end else begin
                do_sub = 1'b1; sub_amt = 33'(f) + 33'(f[0]);
              end
            end
            PH_USEC: begin
              usec_next = f; skip_next = 33'(AVIH_GAP); phase_next = PH_GAP;
            end
            PH_FRAMES: begin
              frames_next = f;
              do_sub = 1'b1; sub_amt = 33'(isz - AVIH_MIN) + 33'(isz[0]);
            end
            default: phase_next = PH_DONE;
          endcase
        end
      end
    endcase

    // Resolve chunk transitions: sub skip, sub walk, top skip, top walk.
    if (do_sub) begin
      if (sub_amt == '0) sub_f = 1'b1;
      else begin
        skip_next = sub_amt; phase_next = PH_SUB_SKIP;
      end
    end
    if (sub_f) begin
      if (pos_x + CW'(8) <= CW'(hle_next)) phase_next = PH_SUB_TAG;
      else begin
        hrest = (CW'(hle_next) > pos_x) ? CW'(hle_next) - pos_x : '0;
        do_top = 1'b1; top_amt = 33'(hrest) + 33'(osz_next[0]);
      end
    end
    if (do_top) begin
      if (top_amt == '0) top_f = 1'b1;
      else begin
        skip_next = top_amt; phase_next = PH_SKIP;
      end
    end
    if (top_f)
      phase_next = (pos_x + CW'(8) <= CW'(limit_next)) ? PH_HDR_TAG : PH_DONE;
  end

  // Work out the status a file ending on this byte would report.
  always_comb begin
    fc = (movi_off_next == '0 || movi_sz_next == '0 || usec_next == '0)
         ? ST_MISSING : ST_OK;
    tgt = pos_x + CW'(skip_next);
    if (err_next != ST_OK) status = err_next;
    else begin
      case (phase_next)
        PH_DONE: status = fc;
        PH_SKIP: status = (tgt + CW'(8) > CW'(limit_next)) ? fc : ST_TRUNCATED;
        PH_SUB_SKIP: begin
          if (tgt + CW'(8) <= CW'(hle_next)) status = ST_TRUNCATED;
          else begin
            if (CW'(hle_next) > tgt) tgt = CW'(hle_next);
            tgt = tgt + CW'(osz_next[0]);
            status = (tgt + CW'(8) > CW'(limit_next)) ? fc : ST_TRUNCATED;
          end
        end
        default: status = ST_TRUNCATED;
      endcase
    end
    result = '{status, movi_off_next, movi_sz_next, idx_off_next, idx_sz_next,
               usec_next, frames_next};
  end

  // Hold state; clear it on reset and after the last byte of a file.
  always_ff @(posedge clk) begin
    if (rst || (step && beat.end_of_file)) begin
      pos <= '0; phase <= PH_RIFF_TAG; shift <= '0; cnt <= '0; tag <= '0;
      limit <= '0; skip <= '0; hle <= '0; osz <= '0; isz <= '0;
      movi_off <= '0; movi_sz <= '0; idx_off <= '0; idx_sz <= '0;
      usec <= '0; frames <= '0; err <= ST_OK;
    end else if (step) begin
      pos <= pos_next; phase <= phase_next; shift <= shift_next; cnt <= cnt_next;
      tag <= tag_next; limit <= limit_next; skip <= skip_next; hle <= hle_next;
      osz <= osz_next; isz <= isz_next; movi_off <= movi_off_next;
      movi_sz <= movi_sz_next; idx_off <= idx_off_next; idx_sz <= idx_sz_next;
      usec <= usec_next; frames <= frames_next; err <= err_next;
    end
  end

endmodule

FILE: src/ars_checker.sv
// Port checker for the AVI RIFF header scanner and its bind.
module ars_checker (
  input logic              clk,
  input logic              rst,
  input logic              byte_stall,
  input logic              result_valid,
  input logic              result_stall,
  input ars_pkg::ars_out_t result
);
  import ars_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= ST_SHORT_AVIH)
    else $error("undefined status code");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK |->
    result.movi_offset != '0 && result.movi_size != '0 && result.usec_per_frame != '0)
    else $error("ok status with essential field missing");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("input stalled while output free");

endmodule

bind avi_riff_header_scanner ars_checker u_ars_checker (
  .clk(clk), .rst(rst), .byte_stall(byte_stall), .result_valid(result_valid),
  .result_stall(result_stall), .result(result)
);

FILE: verif/avi_riff_header_scanner_tb.sv
// Self-checking testbench for the AVI RIFF header scanner: file streams in, results checked.
module avi_riff_header_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ars_pkg::*;

  localparam int OW = OFFSET_WIDTH_DEF;
  localparam logic [63:0] POS_TOP = (64'd1 << (OW + 1)) - 64'd1;
  localparam logic [63:0] OFF_MASK = (64'd1 << OW) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  ars_in_t byte_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ars_out_t result;

  always #10 clk = ~clk;

  avi_riff_header_scanner u_top (
    .clk(clk), .rst(rst), .byte_valid(byte_valid), .byte_stall(byte_stall),
    .byte_data(byte_data), .result_valid(result_valid), .result_stall(result_stall),
    .result(result)
  );

  // Scanner state mirror
  logic [63:0] pos, riff_lim, skip_left, hdrl_end;
  phase_t      phase;
  logic [31:0] shreg, tag_q, outer_sz, inner_sz;
  int          nbytes;
  logic [31:0] fields [6];
  logic [2:0]  err;

  ars_out_t summary_q[$];
  int errors = 0;
  int files_done = 0;
  int bytes_sent = 0;
  logic hold_off = 1'b0;
  logic quiet = 1'b0;
  logic held = 1'b0;
  logic drained = 1'b0;

  function automatic void scan_clear();
    pos = 0; phase = PH_RIFF_TAG; shreg = 0; nbytes = 0; tag_q = 0; riff_lim = 0;
    skip_left = 0; hdrl_end = 0; outer_sz = 0; inner_sz = 0; err = ST_OK;
    for (int k = 0; k < 6; k++) fields[k] = 0;
  endfunction

  function automatic void to_top();
    nbytes = 0;
    phase = (pos + 8 <= riff_lim) ? PH_HDR_TAG : PH_DONE;
  endfunction

  function automatic void top_skip(logic [63:0] n);
    if (n == 0) to_top();
    else begin
      skip_left = n;
      phase = PH_SKIP;
    end
  endfunction

  function automatic void to_sub();
    logic [63:0] rest;
    nbytes = 0;
    if (pos + 8 <= hdrl_end) phase = PH_SUB_TAG;
    else begin
      rest = (hdrl_end > pos) ? hdrl_end - pos : 0;
      top_skip(rest + outer_sz[0]);
    end
  endfunction

  function automatic void sub_skip(logic [63:0] n);
    if (n == 0) to_sub();
    else begin
      skip_left = n;
      phase = PH_SUB_SKIP;
    end
  endfunction

  function automatic logic [2:0] check_found();
    if (fields[0] == 0 || fields[1] == 0 || fields[4] == 0) return ST_MISSING;
    return ST_OK;
  endfunction

  function automatic logic [2:0] closing_status();
    logic [63:0] tgt;
    if (err != ST_OK) return err;
    if (phase == PH_DONE) return check_found();
    if (phase == PH_SKIP) begin
      tgt = pos + skip_left;
      return (tgt + 8 > riff_lim) ? check_found() : ST_TRUNCATED;
    end
    if (phase == PH_SUB_SKIP) begin
      tgt = pos + skip_left;
      if (tgt + 8 <= hdrl_end) return ST_TRUNCATED;
      if (hdrl_end > tgt) tgt = hdrl_end;
      tgt += outer_sz[0];
      return (tgt + 8 > riff_lim) ? check_found() : ST_TRUNCATED;
    end
    return ST_TRUNCATED;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [31:0] f, rest;
    if (phase == PH_DONE) return;
    if (phase == PH_SKIP || phase == PH_SUB_SKIP || phase == PH_GAP) begin
      skip_left--;
      if (skip_left == 0) begin
        if (phase == PH_SKIP) to_top();
        else if (phase == PH_SUB_SKIP) to_sub();
        else begin
          nbytes = 0;
          phase = PH_FRAMES;
        end
      end
      return;
    end
    shreg = {b, shreg[31:8]};
    nbytes++;
    if (nbytes < 4) return;
    nbytes = 0;
    f = shreg;
    case (phase)
      PH_RIFF_TAG: begin
        if (f != TAG_RIFF) begin err = ST_NOT_RIFF; phase = PH_DONE; end
        else phase = PH_RIFF_SIZE;
      end
      PH_RIFF_SIZE: begin
        riff_lim = {32'd0, f} + 8;
        phase = PH_FORM;
      end
      PH_FORM: begin
        if (f != TAG_AVI) begin err = ST_NOT_AVI; phase = PH_DONE; end
        else to_top();
      end
      PH_HDR_TAG: begin
        tag_q = f;
        phase = PH_HDR_SIZE;
      end
      PH_HDR_SIZE: begin
        outer_sz = f;
        if (tag_q == TAG_LIST) phase = PH_LIST_TYPE;
        else begin
          if (tag_q == TAG_IDX1) begin
            fields[2] = 32'(pos & OFF_MASK);
            fields[3] = f;
          end
          top_skip({32'd0, f} + f[0]);
        end
      end
      PH_LIST_TYPE: begin
        rest = (outer_sz >= 4) ? outer_sz - 4 : 0;
        if (f == TAG_HDRL) begin
          hdrl_end = pos + rest;
          to_sub();
        end else begin
          if (f == TAG_MOVI) begin
            fields[0] = 32'(pos & OFF_MASK);
            fields[1] = rest;
          end
          top_skip({32'd0, rest} + outer_sz[0]);
        end
      end
      PH_SUB_TAG: begin
        tag_q = f;
        phase = PH_SUB_SIZE;
      end
      PH_SUB_SIZE: begin
        inner_sz = f;
        if (tag_q == TAG_AVIH) begin
          if (f < AVIH_MIN) begin err = ST_SHORT_AVIH; phase = PH_DONE; end
          else phase = PH_USEC;
        end else sub_skip({32'd0, f} + f[0]);
      end
      PH_USEC: begin
        fields[4] = f;
        skip_left = 64'(AVIH_GAP);
        phase = PH_GAP;
      end
      PH_FRAMES: begin
        fields[5] = f;
        sub_skip({32'd0, inner_sz - AVIH_MIN} + inner_sz[0]);
      end
      default: phase = PH_DONE;
    endcase
  endfunction

  // Advance the mirror by one byte; queue the summary on end of file
  function automatic void predict_byte(ars_in_t it);
    ars_out_t o;
    if (pos < POS_TOP) pos++;
    take_byte(it.data_byte);
    if (!it.end_of_file) return;
    o.status = closing_status();
    o.movi_offset = fields[0];
    o.movi_size = fields[1];
    o.index_offset = fields[2];
    o.index_size = fields[3];
    o.usec_per_frame = fields[4];
    o.frame_count = fields[5];
    summary_q.push_back(o);
    scan_clear();
  endfunction

  // File image under construction
  logic [7:0] img[$];

  function automatic void put32(logic [31:0] v);
    for (int k = 0; k < 4; k++) img.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_fill(int n);
    for (int k = 0; k < n; k++) img.push_back(8'($urandom));
  endfunction

  // Send one byte: wait out the stall, with random idle cycles outside the quiet stretch
  task automatic send_beat(logic [7:0] b, logic eof);
    while (!quiet && $urandom_range(99) < 9) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{data_byte: b, end_of_file: eof};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_byte('{data_byte: b, end_of_file: eof});
    bytes_sent++;
  endtask

  // Send the image with eof on the last byte, optionally cut short
  task automatic send_file(int cut);
    int n;
    n = (cut > 0 && cut < img.size()) ? cut : img.size();
    for (int k = 0; k < n; k++) send_beat(img[k], k == n - 1);
    byte_valid <= 1'b0;
    @(posedge clk);
    img.delete();
  endtask

  // Build a file with random content and optional chunks in fixed order
  task automatic build_file(logic [31:0] usec, int avih_sz, logic with_idx);
    int movi_len, junk_len, hsz;
    movi_len = $urandom_range(0, 9);
    junk_len = $urandom_range(0, 5);
    hsz = 4 + 8 + avih_sz + avih_sz % 2 + (junk_len > 0 ? 8 + junk_len + junk_len % 2 : 0);
    put32(TAG_RIFF);
    put32(0);
    put32(TAG_AVI);
    put32(TAG_LIST); put32(hsz); put32(TAG_HDRL);
    put32(TAG_AVIH); put32(avih_sz);
    put32(usec); put_fill(12); put32($urandom); put_fill(avih_sz - 20 + avih_sz % 2);
    if (junk_len > 0) begin
      put32($urandom); put32(junk_len); put_fill(junk_len + junk_len % 2);
    end
    if ($urandom_range(3) == 0) begin
      put32(32'h4B4E_554A); put32(3); put_fill(4);
    end
    put32(TAG_LIST); put32(4 + movi_len); put32(TAG_MOVI); put_fill(movi_len + movi_len % 2);
    if (with_idx) begin
      put32(TAG_IDX1); put32(movi_len); put_fill(movi_len + movi_len % 2);
    end
    // Patch RIFF size, sometimes a bit long
    begin
      logic [31:0] rs;
      rs = img.size() - 8 + ($urandom_range(3) == 0 ? $urandom_range(0, 6) : 0);
      for (int k = 0; k < 4; k++) img[4 + k] = rs[8*k +: 8];
    end
  endtask

  task automatic wait_drained();
    while (summary_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    ars_out_t exp_o;
    if (!rst && result_valid && !result_stall) begin
      if (summary_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
        errors++;
      end else begin
        exp_o = summary_q.pop_front();
        if (result !== exp_o) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_o, result);
          errors++;
        end
        files_done++;
      end
    end
  end

  // Receiver stall: random, quiet stretch, one long hold-off
  always @(posedge clk) begin
    if (hold_off) result_stall <= 1'b1;
    else if (quiet) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < 9);
  end

  // Directed rows: byte pattern kind, cut point, typed-in status where obvious
  typedef struct {
    int kind;
    int cut;
    logic [2:0] status;
    logic typed;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{0, 1, ST_TRUNCATED, 1'b1},   // one byte only
    '{1, 0, ST_NOT_RIFF, 1'b1},    // wrong RIFF tag
    '{2, 0, ST_NOT_AVI, 1'b1},     // wrong form type
    '{3, 0, ST_SHORT_AVIH, 1'b1},  // avih under 20 bytes
    '{4, 0, ST_OK, 1'b0},          // good file
    '{4, 30, ST_TRUNCATED, 1'b1},  // cut in hdrl, inside the avih size field
    '{5, 0, ST_MISSING, 1'b1},     // no movi
    '{6, 0, ST_OK, 1'b0},          // empty list, size below four
    '{7, 0, ST_OK, 1'b0},          // extreme sizes, end inside skip
    '{8, 0, ST_OK, 1'b0},          // bytes after scan ends
    '{9, 0, ST_OK, 1'b0}           // all-ones and zero bytes
  };

  task automatic build_row(int kind);
    case (kind)
      0: put32(TAG_RIFF);
      1: begin put32(32'hFFFF_FFFF); put32(0); end
      2: begin put32(TAG_RIFF); put32(100); put32(32'h0000_0000); end
      3: begin
        put32(TAG_RIFF); put32(100); put32(TAG_AVI);
        put32(TAG_LIST); put32(40); put32(TAG_HDRL); put32(TAG_AVIH); put32(19);
      end
      4: build_file($urandom | 1, 56, 1'b1);
      5: begin
        put32(TAG_RIFF); put32(12); put32(TAG_AVI);
        put32(32'h4B4E_554A); put32(1); put_fill(2);
      end
      6: begin
        put32(TAG_RIFF); put32(30); put32(TAG_AVI);
        put32(TAG_LIST); put32(3); put32(TAG_MOVI); put_fill(2);
      end
      7: begin
        put32(TAG_RIFF); put32(32'hFFFF_FFFF); put32(TAG_AVI);
        put32(TAG_LIST); put32(32'hFFFF_FFFF); put32(TAG_MOVI); put_fill(3);
      end
      8: begin
        build_file(32'hFFFF_FFFF, 21, 1'b0);
        put_fill(6);
      end
      default: begin
        for (int k = 0; k < 8; k++) img.push_back(k % 2 ? 8'hFF : 8'h00);
      end
    endcase
  endtask

  initial begin
    scan_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    foreach (dir_rows[i]) begin
      build_row(dir_rows[i].kind);
      send_file(dir_rows[i].cut);
      if (dir_rows[i].typed && summary_q.size() > 0 &&
          summary_q[summary_q.size() - 1].status !== dir_rows[i].status) begin
        $display("%0t: mismatch row %0d expected status %0d actual %0d", $time, i,
                 dir_rows[i].status, summary_q[summary_q.size() - 1].status);
        errors++;
      end
    end
    wait_drained();

    // Random part: mostly well-formed files, some broken or noise
    while (bytes_sent < 1450) begin
      int pick;
      pick = $urandom_range(9);
      quiet = (bytes_sent >= 900 && bytes_sent < 1150);
      if (pick < 7) begin
        build_file(($urandom_range(4) == 0) ? 0 : $urandom, $urandom_range(20, 27),
                   $urandom_range(1));
        send_file($urandom_range(4) == 0 ? $urandom_range(1, img.size()) : 0);
      end else if (pick == 7) begin
        build_file($urandom, $urandom_range(0, 25) < 20 ? $urandom_range(0, 19) : 20, 1'b0);
        send_file(0);
      end else begin
        put_fill($urandom_range(1, 12));
        send_file(0);
      end
      // Long receiver hold-off while bytes keep coming, once
      if (bytes_sent >= 700 && !held) begin
        held = 1'b1;
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        build_file($urandom | 1, 20, 1'b1);
        send_file(0);
        build_file($urandom | 1, 24, 1'b1);
        send_file(0);
      end
      // Sender pause until everything is out
      if (bytes_sent >= 1250 && !drained) begin
        drained = 1'b1;
        wait_drained();
      end
    end
    quiet = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes in %0d files: tag errors, short avih, cuts, skips",
             bytes_sent, files_done);
    if (errors == 0) $display("avi_riff_header_scanner_tb: done, clean");
    else $display("avi_riff_header_scanner_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("avi_riff_header_scanner_tb: done, errors");
    $finish;
  end
endmodule
